FILE: src/hpk_pkg.sv
// Shared constants, types and the decode tree builder for the HPACK Huffman decoder.
package hpk_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CAP_W      = 16;
    localparam int NODE_W     = 9;
    localparam int TREE_DEPTH = 2 ** (NODE_W + 1);
    localparam int SYM_TOTAL  = 257;
    localparam int SYM_EOS    = 256;

    // closing status codes
    localparam logic [2:0] ST_OK  = 3'd0;
    localparam logic [2:0] ST_PAD = 3'd1;
    localparam logic [2:0] ST_EOS = 3'd2;
    localparam logic [2:0] ST_OVF = 3'd3;
    localparam logic [2:0] ST_UNK = 3'd4;

    // tree entry: bit 9 leaf flag, low bits symbol or child node; all zero is absent
    typedef logic [NODE_W:0] tree_ent_t;
    typedef tree_ent_t tree_rom_t [0:TREE_DEPTH-1];

    // {length, left-aligned code}
    localparam logic [36:0] CODE_TABLE [0:SYM_TOTAL-1] = '{
        {5'd13, 32'hffc00000}, {5'd23, 32'hffffb000}, {5'd28, 32'hfffffe20}, {5'd28, 32'hfffffe30},
        {5'd28, 32'hfffffe40}, {5'd28, 32'hfffffe50}, {5'd28, 32'hfffffe60}, {5'd28, 32'hfffffe70},
        {5'd28, 32'hfffffe80}, {5'd24, 32'hffffea00}, {5'd30, 32'hfffffff0}, {5'd28, 32'hfffffe90},
        {5'd28, 32'hfffffea0}, {5'd30, 32'hfffffff4}, {5'd28, 32'hfffffeb0}, {5'd28, 32'hfffffec0},
        {5'd28, 32'hfffffed0}, {5'd28, 32'hfffffee0}, {5'd28, 32'hfffffef0}, {5'd28, 32'hffffff00},
        {5'd28, 32'hffffff10}, {5'd28, 32'hffffff20}, {5'd30, 32'hfffffff8}, {5'd28, 32'hffffff30},
        {5'd28, 32'hffffff40}, {5'd28, 32'hffffff50}, {5'd28, 32'hffffff60}, {5'd28, 32'hffffff70},
        {5'd28, 32'hffffff80}, {5'd28, 32'hffffff90}, {5'd28, 32'hffffffa0}, {5'd28, 32'hffffffb0},
        {5'd6, 32'h50000000}, {5'd10, 32'hfe000000}, {5'd10, 32'hfe400000}, {5'd12, 32'hffa00000},
        {5'd13, 32'hffc80000}, {5'd6, 32'h54000000}, {5'd8, 32'hf8000000}, {5'd11, 32'hff400000},
        {5'd10, 32'hfe800000}, {5'd10, 32'hfec00000}, {5'd8, 32'hf9000000}, {5'd11, 32'hff600000},
        {5'd8, 32'hfa000000}, {5'd6, 32'h58000000}, {5'd6, 32'h5c000000}, {5'd6, 32'h60000000},
        {5'd5, 32'h00000000}, {5'd5, 32'h08000000}, {5'd5, 32'h10000000}, {5'd6, 32'h64000000},
        {5'd6, 32'h68000000}, {5'd6, 32'h6c000000}, {5'd6, 32'h70000000}, {5'd6, 32'h74000000},
        {5'd6, 32'h78000000}, {5'd6, 32'h7c000000}, {5'd7, 32'hb8000000}, {5'd8, 32'hfb000000},
        {5'd15, 32'hfff80000}, {5'd6, 32'h80000000}, {5'd12, 32'hffb00000}, {5'd10, 32'hff000000},
        {5'd13, 32'hffd00000}, {5'd6, 32'h84000000}, {5'd7, 32'hba000000}, {5'd7, 32'hbc000000},
        {5'd7, 32'hbe000000}, {5'd7, 32'hc0000000}, {5'd7, 32'hc2000000}, {5'd7, 32'hc4000000},
        {5'd7, 32'hc6000000}, {5'd7, 32'hc8000000}, {5'd7, 32'hca000000}, {5'd7, 32'hcc000000},
        {5'd7, 32'hce000000}, {5'd7, 32'hd0000000}, {5'd7, 32'hd2000000}, {5'd7, 32'hd4000000},
        {5'd7, 32'hd6000000}, {5'd7, 32'hd8000000}, {5'd7, 32'hda000000}, {5'd7, 32'hdc000000},
        {5'd7, 32'hde000000}, {5'd7, 32'he0000000}, {5'd7, 32'he2000000}, {5'd7, 32'he4000000},
        {5'd8, 32'hfc000000}, {5'd7, 32'he6000000}, {5'd8, 32'hfd000000}, {5'd13, 32'hffd80000},
        {5'd19, 32'hfffe0000}, {5'd13, 32'hffe00000}, {5'd14, 32'hfff00000}, {5'd6, 32'h88000000},
        {5'd15, 32'hfffa0000}, {5'd5, 32'h18000000}, {5'd6, 32'h8c000000}, {5'd5, 32'h20000000},
        {5'd6, 32'h90000000}, {5'd5, 32'h28000000}, {5'd6, 32'h94000000}, {5'd6, 32'h98000000},
        {5'd6, 32'h9c000000}, {5'd5, 32'h30000000}, {5'd7, 32'he8000000}, {5'd7, 32'hea000000},
        {5'd6, 32'ha0000000}, {5'd6, 32'ha4000000}, {5'd6, 32'ha8000000}, {5'd5, 32'h38000000},
        {5'd6, 32'hac000000}, {5'd7, 32'hec000000}, {5'd6, 32'hb0000000}, {5'd5, 32'h40000000},
        {5'd5, 32'h48000000}, {5'd6, 32'hb4000000}, {5'd7, 32'hee000000}, {5'd7, 32'hf0000000},
        {5'd7, 32'hf2000000}, {5'd7, 32'hf4000000}, {5'd7, 32'hf6000000}, {5'd15, 32'hfffc0000},
        {5'd11, 32'hff800000}, {5'd14, 32'hfff40000}, {5'd13, 32'hffe80000}, {5'd28, 32'hffffffc0},
        {5'd20, 32'hfffe6000}, {5'd22, 32'hffff4800}, {5'd20, 32'hfffe7000}, {5'd20, 32'hfffe8000},
        {5'd22, 32'hffff4c00}, {5'd22, 32'hffff5000}, {5'd22, 32'hffff5400}, {5'd23, 32'hffffb200},
        {5'd22, 32'hffff5800}, {5'd23, 32'hffffb400}, {5'd23, 32'hffffb600}, {5'd23, 32'hffffb800},
        {5'd23, 32'hffffba00}, {5'd23, 32'hffffbc00}, {5'd24, 32'hffffeb00}, {5'd23, 32'hffffbe00},
        {5'd24, 32'hffffec00}, {5'd24, 32'hffffed00}, {5'd22, 32'hffff5c00}, {5'd23, 32'hffffc000},
        {5'd24, 32'hffffee00}, {5'd23, 32'hffffc200}, {5'd23, 32'hffffc400}, {5'd23, 32'hffffc600},
        {5'd23, 32'hffffc800}, {5'd21, 32'hfffee000}, {5'd22, 32'hffff6000}, {5'd23, 32'hffffca00},
        {5'd22, 32'hffff6400}, {5'd23, 32'hffffcc00}, {5'd23, 32'hffffce00}, {5'd24, 32'hffffef00},
        {5'd22, 32'hffff6800}, {5'd21, 32'hfffee800}, {5'd20, 32'hfffe9000}, {5'd22, 32'hffff6c00},
        {5'd22, 32'hffff7000}, {5'd23, 32'hffffd000}, {5'd23, 32'hffffd200}, {5'd21, 32'hfffef000},
        {5'd23, 32'hffffd400}, {5'd22, 32'hffff7400}, {5'd22, 32'hffff7800}, {5'd24, 32'hfffff000},
        {5'd21, 32'hfffef800}, {5'd22, 32'hffff7c00}, {5'd23, 32'hffffd600}, {5'd23, 32'hffffd800},
        {5'd21, 32'hffff0000}, {5'd21, 32'hffff0800}, {5'd22, 32'hffff8000}, {5'd21, 32'hffff1000},
        {5'd23, 32'hffffda00}, {5'd22, 32'hffff8400}, {5'd23, 32'hffffdc00}, {5'd23, 32'hffffde00},
        {5'd20, 32'hfffea000}, {5'd22, 32'hffff8800}, {5'd22, 32'hffff8c00}, {5'd22, 32'hffff9000},
        {5'd23, 32'hffffe000}, {5'd22, 32'hffff9400}, {5'd22, 32'hffff9800}, {5'd23, 32'hffffe200},
        {5'd26, 32'hfffff800}, {5'd26, 32'hfffff840}, {5'd20, 32'hfffeb000}, {5'd19, 32'hfffe2000},
        {5'd22, 32'hffff9c00}, {5'd23, 32'hffffe400}, {5'd22, 32'hffffa000}, {5'd25, 32'hfffff600},
        {5'd26, 32'hfffff880}, {5'd26, 32'hfffff8c0}, {5'd26, 32'hfffff900}, {5'd27, 32'hfffffbc0},
        {5'd27, 32'hfffffbe0}, {5'd26, 32'hfffff940}, {5'd24, 32'hfffff100}, {5'd25, 32'hfffff680},
        {5'd19, 32'hfffe4000}, {5'd21, 32'hffff1800}, {5'd26, 32'hfffff980}, {5'd27, 32'hfffffc00},
        {5'd27, 32'hfffffc20}, {5'd26, 32'hfffff9c0}, {5'd27, 32'hfffffc40}, {5'd24, 32'hfffff200},
        {5'd21, 32'hffff2000}, {5'd21, 32'hffff2800}, {5'd26, 32'hfffffa00}, {5'd26, 32'hfffffa40},
        {5'd28, 32'hffffffd0}, {5'd27, 32'hfffffc60}, {5'd27, 32'hfffffc80}, {5'd27, 32'hfffffca0},
        {5'd20, 32'hfffec000}, {5'd24, 32'hfffff300}, {5'd20, 32'hfffed000}, {5'd21, 32'hffff3000},
        {5'd22, 32'hffffa400}, {5'd21, 32'hffff3800}, {5'd21, 32'hffff4000}, {5'd23, 32'hffffe600},
        {5'd22, 32'hffffa800}, {5'd22, 32'hffffac00}, {5'd25, 32'hfffff700}, {5'd25, 32'hfffff780},
        {5'd24, 32'hfffff400}, {5'd24, 32'hfffff500}, {5'd26, 32'hfffffa80}, {5'd23, 32'hffffe800},
        {5'd26, 32'hfffffac0}, {5'd27, 32'hfffffcc0}, {5'd26, 32'hfffffb00}, {5'd26, 32'hfffffb40},
        {5'd27, 32'hfffffce0}, {5'd27, 32'hfffffd00}, {5'd27, 32'hfffffd20}, {5'd27, 32'hfffffd40},
        {5'd27, 32'hfffffd60}, {5'd28, 32'hffffffe0}, {5'd27, 32'hfffffd80}, {5'd27, 32'hfffffda0},
        {5'd27, 32'hfffffdc0}, {5'd27, 32'hfffffde0}, {5'd27, 32'hfffffe00}, {5'd26, 32'hfffffb80},
        {5'd30, 32'hfffffffc}
    };

    // Builds the decode tree at elaboration; entry index is {node, bit}
    function automatic tree_rom_t build_tree();
        tree_rom_t t;
        int used;
        int node;
        int len;
        int b;
        logic [31:0] w;
        tree_ent_t c;
        logic dead;
        for (int i = 0; i < TREE_DEPTH; i++)
        begin
            t[i] = '0;
        end
        used = 1;
        for (int s = 0; s < SYM_TOTAL; s++)
        begin
            len  = int'(CODE_TABLE[s][36:32]);
            w    = CODE_TABLE[s][31:0];
            node = 0;
            dead = 1'b0;
            for (int i = 0; i < len - 1; i++)
            begin
                if (!dead)
                begin
                    b = int'(w[31 - i]);
                    c = t[node * 2 + b];
                    if (c[NODE_W])
                    begin
                        dead = 1'b1;
                    end
                    else if (c == '0)
                    begin
                        if (used >= 2 ** NODE_W)
                        begin
                            dead = 1'b1;
                        end
                        else
                        begin
                            c = tree_ent_t'(used);
                            t[node * 2 + b] = c;
                            used = used + 1;
                        end
                    end
                    if (!dead)
                    begin
                        node = int'(c[NODE_W-1:0]);
                    end
                end
            end
            if (!dead)
            begin
                b = int'(w[32 - len]);
                if (t[node * 2 + b] == '0)
                begin
                    t[node * 2 + b] = {1'b1, NODE_W'(s)};
                end
            end
        end
        return t;
    endfunction

endpackage

FILE: src/hpk_tree_rom.sv
// Decode tree ROM with a registered read port.
module hpk_tree_rom
    import hpk_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [NODE_W:0]   rd_addr,
    output tree_ent_t         rd_data
);

    localparam tree_rom_t TREE = build_tree();

    tree_ent_t data_reg;

    // registered read, data holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= TREE[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

FILE: src/hpack_huffman_decoder.sv
// Top level of the HPACK Huffman string decoder.
// Each coded byte is accepted in the idle state, then takes eight tree steps (one read of the
// decode tree ROM per bit, the next address taken from the entry just read), and a flush step;
// the final byte of a string adds a close step for the closing result. A tree step that would
// emit a second symbol waits while the output is held off, as do the flush and close steps.
// After an error the remaining bits of each byte are skipped. The user must write out_capacity
// via cfg_we only while no string byte is in flight; the block itself does not enforce this.
module hpack_huffman_decoder
    import hpk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte[7:0], status[10:8], out_count[26:11], zero
    output logic [1:0]  m_tuser,   // byte_valid, string_end
    output logic        m_tlast    // run_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_CLOSE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [2:0]            bit_reg, bit_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic                  ones_reg, ones_next;
    logic [2:0]            err_reg, err_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [CAP_W-1:0]      cap_reg;
    logic                  pend_valid_reg, pend_valid_next;
    logic [7:0]            pend_byte_reg, pend_byte_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_data_reg, out_data_next;
    logic [1:0]            out_user_reg, out_user_next;
    logic                  out_last_reg, out_last_next;

    logic                  rd_en;
    logic [NODE_W:0]       rd_addr;
    tree_ent_t             ent;
    logic                  slot_free;
    logic                  emit;
    logic                  advance;
    logic                  overflow;
    logic [2:0]            close_st;

    hpk_tree_rom u_rom (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ent)
    );

    assign slot_free = !out_valid_reg || m_tready;
    assign overflow  = (32'(count_reg) >= 32'(cap_reg)) || (&count_reg);
    assign close_st  = (err_reg != ST_OK) ? err_reg
                     : ((node_reg != '0) && !ones_reg) ? ST_PAD : ST_OK;

    // walk control and result staging
    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        bit_next        = bit_reg;
        node_next       = node_reg;
        ones_next       = ones_reg;
        err_next        = err_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = {node_reg, s_tdata[7]};
        s_tready        = (state_reg == S_IDLE);
        emit            = 1'b0;
        advance         = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next  = s_tdata;
                    last_next  = s_tlast;
                    bit_next   = 3'd7;
                    rd_en      = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (err_reg != ST_OK)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    // one tree step for the current bit
                    if (ent == '0)
                    begin
                        err_next  = ST_UNK;
                        node_next = '0;
                        ones_next = 1'b1;
                    end
                    else if (ent[NODE_W])
                    begin
                        node_next = '0;
                        ones_next = 1'b1;
                        if (ent[NODE_W-1:0] == NODE_W'(SYM_EOS))
                        begin
                            err_next = ST_EOS;
                        end
                        else if (overflow)
                        begin
                            err_next = ST_OVF;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    else
                    begin
                        node_next = ent[NODE_W-1:0];
                        ones_next = ones_reg & byte_reg[bit_reg];
                    end
                    // a second symbol needs the staged one moved out first
                    if (emit && pend_valid_reg && !slot_free)
                    begin
                        advance = 1'b0;
                    end
                    if (advance)
                    begin
                        if (emit)
                        begin
                            count_next      = count_reg + 1'b1;
                            pend_valid_next = 1'b1;
                            pend_byte_next  = ent[7:0];
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = {24'd0, pend_byte_reg};
                                out_user_next  = 2'b01;
                                out_last_next  = 1'b0;
                            end
                        end
                        if (bit_reg == 3'd0)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            bit_next = bit_reg - 3'd1;
                            rd_en    = 1'b1;
                            rd_addr  = {node_next, byte_reg[bit_reg - 3'd1]};
                        end
                    end
                    else
                    begin
                        node_next = node_reg;
                        ones_next = ones_reg;
                        err_next  = err_reg;
                    end
                end
            end
            S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = {24'd0, pend_byte_reg};
                        out_user_next   = 2'b01;
                        out_last_next   = !last_reg;
                        pend_valid_next = 1'b0;
                        state_next      = last_reg ? S_CLOSE : S_IDLE;
                    end
                end
                else
                begin
                    state_next = last_reg ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'd0, 16'(count_reg), close_st, 8'd0};
                    out_user_next  = 2'b10;
                    out_last_next  = 1'b1;
                    node_next      = '0;
                    ones_next      = 1'b1;
                    err_next       = ST_OK;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_reg       <= '0;
            ones_reg       <= 1'b1;
            err_reg        <= ST_OK;
            count_reg      <= '0;
            cap_reg        <= '1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_reg       <= node_next;
            ones_reg       <= ones_next;
            err_reg        <= err_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        bit_reg       <= bit_next;
        pend_byte_reg <= pend_byte_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // checks
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_valid_reg)
        else $error("staged symbol left over at byte boundary");
    a_sym_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
        else $error("symbol item marked as string end");
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("closing item without tlast");
    a_err_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && err_reg != ST_OK) |=> (state_reg == S_FLUSH))
        else $error("bits walked after an error");
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLOSE && slot_free) |=> (count_reg == '0 && err_reg == ST_OK))
        else $error("string state not cleared at close");

endmodule

FILE: tb/hpack_huffman_decoder_checker.sv
// Output checker for the HPACK Huffman decoder: decode-tree predictor and item comparison.
`timescale 1ns / 1ps

module hpack_huffman_decoder_checker
    import hpk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0]  sym;
        logic        sym_valid;
        logic        byte_done;
        logic        str_end;
        logic [2:0]  status;
        logic [15:0] count;
    } decode_res_t;

    // predictor tree, same layout as the decoder ROM: index {node, bit}
    tree_ent_t   walk_tree [0:TREE_DEPTH-1];
    decode_res_t expected_q [$];
    logic [15:0] capacity;
    logic [8:0]  node;
    logic        ones_path;
    logic [2:0]  err_state;
    logic [15:0] emitted;

    // build the tree from the code table
    initial
    begin
        int used;
        int nd;
        int ln;
        int b;
        logic [31:0] w;
        tree_ent_t c;
        for (int i = 0; i < TREE_DEPTH; i++)
        begin
            walk_tree[i] = '0;
        end
        used = 1;
        for (int s = 0; s < SYM_TOTAL; s++)
        begin
            ln = int'(CODE_TABLE[s][36:32]);
            w  = CODE_TABLE[s][31:0];
            nd = 0;
            for (int i = 0; i < ln - 1; i++)
            begin
                b = int'(w[31 - i]);
                c = walk_tree[nd * 2 + b];
                if (c == '0)
                begin
                    c = tree_ent_t'(used);
                    walk_tree[nd * 2 + b] = c;
                    used++;
                end
                nd = int'(c[NODE_W-1:0]);
            end
            b = int'(w[32 - ln]);
            walk_tree[nd * 2 + b] = {1'b1, NODE_W'(s)};
        end
    end

    task automatic report_mismatch(input string what, input decode_res_t got,
                                   input decode_res_t exp);
        $display("%0t MISMATCH %s: got %h exp %h", $realtime, what, got, exp);
        fail_count++;
    endtask

    // walk the eight bits of one coded byte and, on the last byte, predict the closing item
    task automatic decode_byte(input logic [7:0] data, input logic last);
        decode_res_t r;
        decode_res_t outs [$];
        tree_ent_t c;
        logic [2:0] st;
        for (int i = 7; i >= 0; i--)
        begin
            if (err_state != ST_OK)
                continue;
            c = walk_tree[{node, data[i]}];
            if (c == '0)
            begin
                err_state = ST_UNK;
                node = '0;
                ones_path = 1'b1;
            end
            else if (c[NODE_W])
            begin
                node = '0;
                ones_path = 1'b1;
                if (int'(c[NODE_W-1:0]) == SYM_EOS)
                    err_state = ST_EOS;
                else if (emitted >= capacity || emitted == 16'hffff)
                    err_state = ST_OVF;
                else if (outs.size() < 2)
                begin
                    r = '0;
                    r.sym = c[7:0];
                    r.sym_valid = 1'b1;
                    outs.push_back(r);
                    emitted++;
                end
            end
            else
            begin
                node = c[NODE_W-1:0];
                ones_path &= data[i];
            end
        end
        if (last)
        begin
            st = err_state;
            if (st == ST_OK && node != '0 && !ones_path)
                st = ST_PAD;
            r = '0;
            r.str_end = 1'b1;
            r.status = st;
            r.count = emitted;
            outs.push_back(r);
            node = '0;
            ones_path = 1'b1;
            err_state = ST_OK;
            emitted = '0;
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].byte_done = 1'b1;
        foreach (outs[k])
            expected_q.push_back(outs[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decode_res_t got;
        if (!rst_n)
        begin
            capacity   <= 16'hffff;
            node       = '0;
            ones_path  = 1'b1;
            err_state  = ST_OK;
            emitted    = '0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
                capacity <= cfg_wdata;
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.sym       = m_tdata[7:0];
                got.status    = m_tdata[10:8];
                got.count     = m_tdata[26:11];
                got.sym_valid = m_tuser[0];
                got.str_end   = m_tuser[1];
                got.byte_done = m_tlast;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected item", got, '0);
                else
                begin
                    if (got != expected_q[0] || m_tdata[31:27] != '0)
                        report_mismatch("item", got, expected_q[0]);
                    void'(expected_q.pop_front());
                end
            end
        end
    end

    assign pending = expected_q.size();

endmodule

FILE: tb/tb.sv
// Testbench top for the HPACK Huffman decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb
    import hpk_pkg::*;
();

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          burst_left;
    int          gap_left;
    int          stall_mode;

    hpack_huffman_decoder u_top (.*);
    hpack_huffman_decoder_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls: mode changes per phase, from never stalling to heavy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_mode == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 9) >= stall_mode * 3);
    end

    // watchdog: cycles with no accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // push one coded byte, holding valid through a burst, with random gaps between bursts
    task automatic send_byte(input logic [7:0] data, input logic last);
        if (burst_left == 0)
        begin
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 10);
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap_left) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain_and_park();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        drain_and_park();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // bit-packs a list of symbols with ones padding (or a custom tail)
    task automatic send_symbols(input int syms [$], input int pad_bits, input logic [31:0] pad);
        logic [63:0] acc;
        int nbits;
        int ln;
        acc = '0;
        nbits = 0;
        foreach (syms[k])
        begin
            ln = int'(CODE_TABLE[syms[k]][36:32]);
            for (int i = 0; i < ln; i++)
            begin
                acc = {acc[62:0], CODE_TABLE[syms[k]][31 - i]};
                nbits++;
                if (nbits == 8)
                begin
                    send_byte(acc[7:0], 1'b0);
                    nbits = 0;
                end
            end
        end
        for (int i = 0; i < pad_bits; i++)
        begin
            acc = {acc[62:0], pad[31 - i]};
            nbits++;
            if (nbits == 8 && i != pad_bits - 1)
            begin
                send_byte(acc[7:0], 1'b0);
                nbits = 0;
            end
        end
        if (nbits == 0)
            send_byte(acc[7:0], 1'b1);
        else
            send_byte(acc[7:0] << (8 - nbits), 1'b1);
    endtask

    task automatic random_string(input int max_syms);
        int syms [$];
        int n;
        int pad;
        n = $urandom_range(1, max_syms);
        for (int i = 0; i < n; i++)
            syms.push_back($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                        : $urandom_range(32, 126));
        pad = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
            0: send_symbols(syms, pad + 1, 32'h0);             // bad padding
            1: send_symbols(syms, 30, 32'hfffffffc);          // EOS in data
            2: send_symbols(syms, $urandom_range(8, 20), '1); // long ones padding
            default: send_symbols(syms, pad, '1);
        endcase
    endtask

    initial
    begin
        int syms [$];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short codes up to two per byte in an ok string, then other directed cases
        syms = '{48, 49, 50, 97, 99};
        send_symbols(syms, 7, '1);
        syms = '{0, 255, 10, 13};
        send_symbols(syms, 3, '1);
        syms.delete();
        send_symbols(syms, 30, 32'hfffffffc);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h07, 1'b1);
        syms = '{101, 101};
        send_symbols(syms, 4, 32'h50000000);

        // overflow at capacity zero and two
        write_capacity(16'd0);
        syms = '{48, 49};
        send_symbols(syms, 6, '1);
        write_capacity(16'd2);
        syms = '{48, 49, 50, 97};
        send_symbols(syms, 4, '1);
        syms = '{48, 49};
        send_symbols(syms, 6, '1);

        // random phases over several capacities and stall patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_capacity(16'hffff);
                1: write_capacity(16'd3);
                2: write_capacity(16'd1);
                3: write_capacity(16'h8000);
                4: write_capacity(16'd7);
                default: write_capacity(16'hffff);
            endcase
            stall_mode = ph % 4;
            for (int k = 0; k < 12; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    random_string(8);
            end
        end

        drain_and_park();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
